/* sv/lbsa_pkg.sv */
package lbsa_pkg;

   // fixed field widths
   localparam int BIN_W    = 13;
   localparam int BASE_W   = 5;
   localparam int AMP_W    = 16;
   localparam int PHASE_W  = 16;
   localparam int SLICE_W  = 8;
   localparam int STEP_W   = 6;
   localparam int Z_W      = 26;
   localparam int CORDIC_N = 24;

   // register indexes
   localparam logic CSR_LOG_BASE    = 1'b0;
   localparam logic CSR_HALF_LENGTH = 1'b1;

   // controller commands to the datapath
   typedef struct packed {
      logic              accept;
      logic              sq_re;
      logic              sq_im;
      logic              add;
      logic              root_step;
      logic              cordic_step;
      logic              div_step;
      logic              out_load;
      logic [STEP_W-1:0] step;
   } cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic emit;
   } status_type;

   // arctangent of 2^-i in units of 2^-24 turn
   function automatic logic signed [Z_W-1:0] atan_val(input logic [4:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         5'd0:  v = 26'sd2097152;
         5'd1:  v = 26'sd1238021;
         5'd2:  v = 26'sd654136;
         5'd3:  v = 26'sd332050;
         5'd4:  v = 26'sd166669;
         5'd5:  v = 26'sd83416;
         5'd6:  v = 26'sd41718;
         5'd7:  v = 26'sd20860;
         5'd8:  v = 26'sd10430;
         5'd9:  v = 26'sd5215;
         5'd10: v = 26'sd2608;
         5'd11: v = 26'sd1304;
         5'd12: v = 26'sd652;
         5'd13: v = 26'sd326;
         5'd14: v = 26'sd163;
         5'd15: v = 26'sd81;
         5'd16: v = 26'sd41;
         5'd17: v = 26'sd20;
         5'd18: v = 26'sd10;
         5'd19: v = 26'sd5;
         5'd20: v = 26'sd3;
         5'd21: v = 26'sd1;
         5'd22: v = 26'sd1;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

endpackage

/* sv/lbsa_ctrl.sv */
module lbsa_ctrl
   import lbsa_pkg::*;
#(
   parameter int STEPS = 29
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SQ_RE = 3'd1;
   localparam logic [2:0] ST_SQ_IM = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_ROOT  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
   localparam logic [STEP_W-1:0] CORDIC_END = STEP_W'(CORDIC_N);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.emit) state_in = ST_SQ_RE;
            end
         end
         ST_SQ_RE: begin
            cmd.sq_re = 1'b1;
            state_in  = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            cmd.sq_im = 1'b1;
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step   = 1'b1;
            cmd.cordic_step = (step_ff < CORDIC_END);
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) valid_in = 1'b0;
      if (cmd.out_load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!valid_ff || rsp_tready)) |=> valid_ff)
      else $error("result load did not raise valid");
   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT || state_ff == ST_DIV) |-> step_ff <= LAST_STEP)
      else $error("step counter overran");
   a_emit_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && status.emit) |=> state_ff == ST_SQ_RE)
      else $error("emitting transaction did not start the math");

endmodule

/* sv/lbsa_datapath.sv */
module lbsa_datapath
   import lbsa_pkg::*;
#(
   parameter int MAX_HALF_BINS = 4096,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [BIN_W-1:0]              csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0] bin_real,
   input  logic signed [SAMPLE_BITS-1:0] bin_imag,
   input  logic                          frame_start,
   input  cmd_type                       cmd,
   output status_type                    status,
   output logic [AMP_W-1:0]              band_amplitude,
   output logic signed [PHASE_W-1:0]     band_phase,
   output logic [BIN_W-1:0]              band_center_twice,
   output logic                          band_last
);

   localparam int SUM_W  = SAMPLE_BITS + BIN_W;
   localparam int PROD_W = 2 * SUM_W;
   localparam int REM_W  = SUM_W + 3;
   localparam int CW     = SUM_W + 35;
   localparam logic [BIN_W-1:0] BIN_MAX = '1;

   // configuration registers
   logic [BASE_W-1:0] base_ff;
   logic [BIN_W-1:0]  half_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_W'(2);
         half_ff <= BIN_W'(512);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LOG_BASE:    base_ff <= csr_wdata[BASE_W-1:0];
            CSR_HALF_LENGTH: half_ff <= csr_wdata;
            default:         base_ff <= base_ff;
         endcase
      end
   end

   // slice bookkeeping
   logic [BIN_W-1:0]        bin_cnt_ff, first_ff, width_ff;
   logic [SLICE_W-1:0]      slices_ff;
   logic signed [SUM_W-1:0] sum_re_ff, sum_im_ff;

   logic [BIN_W-1:0]        idx, hl, cnt, center;
   logic [BIN_W:0]          last_of;
   logic                    in_range, is_last, emit;
   logic signed [SUM_W-1:0] sum_re_new, sum_im_new;
   logic [BASE_W-1:0]       base_c;
   logic [9:0]              sq;
   logic [17:0]             wide_w;
   logic [BIN_W-1:0]        width_next;
   logic                    width_grow;

   always_comb begin
      idx = frame_start ? '0 : bin_cnt_ff;
      if (32'(half_ff) > 32'(MAX_HALF_BINS)) hl = BIN_W'(MAX_HALF_BINS);
      else hl = half_ff;
      in_range   = (idx != '0) && (hl >= BIN_W'(2)) && (idx < hl);
      sum_re_new = sum_re_ff + SUM_W'(bin_real);
      sum_im_new = sum_im_ff + SUM_W'(bin_imag);
      last_of    = {1'b0, first_ff} + {1'b0, width_ff} - 1'b1;
      is_last    = (idx >= hl - 1'b1);
      emit       = in_range && (({1'b0, idx} >= last_of) || is_last);
      cnt        = (idx >= first_ff) ? (idx - first_ff + 1'b1) : BIN_W'(1);
      center     = first_ff + idx;
      if (base_ff == '0) base_c = BASE_W'(1);
      else if (base_ff > BASE_W'(16)) base_c = BASE_W'(16);
      else base_c = base_ff;
      sq         = {5'b0, base_c} * {5'b0, base_c};
      width_grow = ({2'b0, slices_ff} + 10'd1 >= sq);
      wide_w     = {5'b0, width_ff} * {13'b0, base_c};
      width_next = (wide_w > 18'(BIN_MAX)) ? BIN_MAX : wide_w[BIN_W-1:0];
   end

   assign status.emit = emit;

   // work registers of the emitted slice
   logic signed [SUM_W-1:0] wr_re_ff, wr_im_ff;
   logic [BIN_W-1:0]        cnt_ff, center_ff;
   logic                    last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_cnt_ff <= '0;
         first_ff   <= BIN_W'(1);
         width_ff   <= BIN_W'(1);
         slices_ff  <= '0;
         sum_re_ff  <= '0;
         sum_im_ff  <= '0;
      end else if (cmd.accept) begin
         bin_cnt_ff <= (idx == BIN_MAX) ? BIN_MAX : idx + 1'b1;
         if (idx == '0) begin
            first_ff  <= BIN_W'(1);
            width_ff  <= BIN_W'(1);
            slices_ff <= '0;
            sum_re_ff <= '0;
            sum_im_ff <= '0;
         end else if (in_range) begin
            if (emit) begin
               first_ff  <= idx + 1'b1;
               sum_re_ff <= '0;
               sum_im_ff <= '0;
               if (width_grow) begin
                  width_ff  <= width_next;
                  slices_ff <= '0;
               end else begin
                  slices_ff <= slices_ff + 1'b1;
               end
            end else begin
               sum_re_ff <= sum_re_new;
               sum_im_ff <= sum_im_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && emit) begin
         wr_re_ff  <= sum_re_new;
         wr_im_ff  <= sum_im_new;
         cnt_ff    <= cnt;
         center_ff <= center;
         last_ff   <= is_last;
      end
   end

   // shared squaring multiplier
   logic signed [SUM_W-1:0]  mul_op;
   logic signed [PROD_W-1:0] mul_res;
   logic [PROD_W-1:0]        prod_ff, acc_ff, rad_ff;

   assign mul_op  = cmd.sq_re ? wr_re_ff : wr_im_ff;
   assign mul_res = mul_op * mul_op;

   // digit-by-digit square root, then restoring divide on the same register
   logic [REM_W-1:0] srem_ff, srem_sh, trial;
   logic [SUM_W-1:0] root_ff;
   logic [BIN_W-1:0] drem_ff;
   logic [BIN_W:0]   drem_sh;
   logic             s_ge, d_ge;

   always_comb begin
      srem_sh = {srem_ff[REM_W-3:0], rad_ff[PROD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      s_ge    = (srem_sh >= trial);
      drem_sh = {drem_ff, root_ff[SUM_W-1]};
      d_ge    = (drem_sh >= {1'b0, cnt_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_re || cmd.sq_im) prod_ff <= PROD_W'(mul_res);
      if (cmd.sq_im) acc_ff <= prod_ff;
      if (cmd.add) begin
         rad_ff  <= acc_ff + prod_ff;
         srem_ff <= '0;
         root_ff <= '0;
         drem_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[PROD_W-3:0], 2'b00};
         srem_ff <= s_ge ? srem_sh - trial : srem_sh;
         root_ff <= {root_ff[SUM_W-2:0], s_ge};
      end else if (cmd.div_step) begin
         drem_ff <= d_ge ? BIN_W'(drem_sh - {1'b0, cnt_ff}) : drem_sh[BIN_W-1:0];
         root_ff <= {root_ff[SUM_W-2:0], d_ge};
      end
   end

   // cordic vectoring for the phase
   logic signed [CW-1:0]  x_ff, y_ff, x0, y0, dx, dy, ext_re, ext_im;
   logic signed [Z_W-1:0] z_ff, z0, atan_i;
   logic                  zero_ff;

   always_comb begin
      ext_re = CW'(wr_re_ff) <<< 32;
      ext_im = CW'(wr_im_ff) <<< 32;
      x0 = ext_re;
      y0 = ext_im;
      z0 = '0;
      if (wr_re_ff < 0) begin
         if (wr_im_ff >= 0) begin
            x0 = ext_im;
            y0 = -ext_re;
            z0 = Z_W'(1 << 22);
         end else begin
            x0 = -ext_im;
            y0 = ext_re;
            z0 = -Z_W'(1 << 22);
         end
      end
      dx     = y_ff >>> cmd.step;
      dy     = x_ff >>> cmd.step;
      atan_i = atan_val(cmd.step[4:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_re) begin
         x_ff    <= x0;
         y_ff    <= y0;
         z_ff    <= z0;
         zero_ff <= (wr_re_ff == 0) && (wr_im_ff == 0);
      end else if (cmd.cordic_step) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_i;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_i;
         end
      end
   end

   // result register
   logic [Z_W-1:0] z_rnd;
   assign z_rnd = z_ff + Z_W'(128);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         band_amplitude    <= (|root_ff[SUM_W-1:AMP_W]) ? '1 : root_ff[AMP_W-1:0];
         band_phase        <= zero_ff ? '0 : z_rnd[23:8];
         band_center_twice <= center_ff;
         band_last         <= last_ff;
      end
   end

endmodule

/* sv/log_band_spectrum_averager.sv */
// Log-band spectrum averager.
// Input stream (req_): one complex spectrum bin per transaction, tuser high on
// bin 0 of a frame. Bin 0 and bins at or above half_length are dropped; the
// rest are grouped into slices that widen by log_base every log_base^2 slices.
// Result stream (rsp_): one transaction per finished slice carrying the mean
// amplitude, the phase of the slice sum and the doubled slice center; tlast
// marks the slice that ends the frame.
// A bin that closes a slice starts the computation: squaring of the real and
// then the imaginary sum on the shared multiplier, an add, one root bit per
// cycle (the 24-step phase rotation runs alongside), one quotient bit per
// cycle, and a final load of the result. req_tready is low during that
// computation.
// The finished result sits in an output register, so the next bin is taken
// while the receiver stalls; only a second result waits for the first to go.
// Reset (synchronous, active high) sets log_base 2, half_length 512 and the
// bin counter to zero, so the first bin after reset counts as bin 0.
// Configuration is written on csr_we: index 0 log_base, index 1 half_length.
module log_band_spectrum_averager
   import lbsa_pkg::*;
#(
   parameter int MAX_HALF_BINS = 4096,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic                                    csr_addr,
   input  logic [BIN_W-1:0]                        csr_wdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // bin_real, bin_imag
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   // frame_start
   input  logic                                    req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // band_amplitude, band_phase, band_center_twice
   output logic [47:0]                             rsp_tdata,
   output logic                                    rsp_tlast
);

   localparam int SUM_W = SAMPLE_BITS + BIN_W;

   cmd_type                 cmd;
   status_type              status;
   logic [AMP_W-1:0]        amp;
   logic signed [PHASE_W-1:0] phase;
   logic [BIN_W-1:0]        center;

   lbsa_ctrl #(
      .STEPS(SUM_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lbsa_datapath #(
      .MAX_HALF_BINS(MAX_HALF_BINS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .bin_real          (req_tdata[SAMPLE_BITS-1:0]),
      .bin_imag          (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .frame_start       (req_tuser),
      .cmd               (cmd),
      .status            (status),
      .band_amplitude    (amp),
      .band_phase        (phase),
      .band_center_twice (center),
      .band_last         (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, center, phase, amp};

endmodule
